// ----- src/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

	// Defaults of the top level parameters
	localparam int MAX_SLOTS_DEF  = 256;
	localparam int OWNER_BITS_DEF = 16;

	// Fixed field widths of the stream and configuration ports
	localparam int OP_W        = 2;
	localparam int SLOT_W      = 8;
	localparam int OWNER_W     = 16;
	localparam int STATUS_W    = 3;
	localparam int COUNT_W     = 9;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;

	// Room for any latched capacity over the whole parameter range
	localparam int CAP_BITS = 17;

	// Free-slot search works on groups of this many slots
	localparam int GROUP_BITS = 4;
	localparam int GROUP_SIZE = 16;

	localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET = 9'd256;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY      = 1'b0,
		REG_TABLE_PRESENT = 1'b1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_NO_TABLE     = 3'd1,
		ST_BAD_SLOT     = 3'd2,
		ST_BAD_ID       = 3'd3,
		ST_ALREADY_FREE = 3'd4,
		ST_FULL         = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CMD_NO_TABLE = 3'd0,
		CMD_BAD_ID   = 3'd1,
		CMD_BAD_SLOT = 3'd2,
		CMD_ALLOC    = 3'd3,
		CMD_RELEASE  = 3'd4,
		CMD_READ     = 3'd5,
		CMD_NOP      = 3'd6
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [SLOT_W-1:0]   slot;
		logic [OWNER_W-1:0]  owner;
	} cmd_t;

	typedef struct packed {
		logic                present;
		logic [CAP_BITS-1:0] active_cap;
	} tbl_info_t;

	typedef enum logic {
		ENG_IDLE = 1'b0,
		ENG_EXEC = 1'b1
	} eng_state_t;

endpackage

`default_nettype wire

// ----- src/ffsa_front.sv -----
// ----------------------------------------------------------------------------
// ffsa_front
// Takes request transfers and classifies them against the table state:
// no table, bad owner id and bad slot are settled here.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_front #(
	parameter int OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// op [1:0], slot_index [9:2], owner_id [25:10], zero [31:26]
	input  wire  [ffsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  wire  ffsa_pkg::tbl_info_t           info,
	input  wire                                 q_full,
	output logic                                q_push,
	output ffsa_pkg::cmd_t                      q_cmd
);
	import ffsa_pkg::*;

	op_t                 op;
	logic [SLOT_W-1:0]   slot;
	logic [OWNER_W-1:0]  owner;
	logic [31:0]         owner_high;
	logic                id_ok;
	logic                slot_ok;
	logic                busy_q;

	assign op    = op_t'(s_axis_tdata[OP_W-1:0]);
	assign slot  = s_axis_tdata[OP_W +: SLOT_W];
	assign owner = s_axis_tdata[OP_W+SLOT_W +: OWNER_W];

	// Bits of the id above the stored owner width must be clear
	assign owner_high = {16'b0, owner} >> OWNER_BITS;
	assign id_ok      = (owner != '0) && (owner_high == '0);
	assign slot_ok    = {{(32-SLOT_W){1'b0}}, slot} < {{(32-CAP_BITS){1'b0}}, info.active_cap};

	// Registered flag that holds off s_axis right after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign s_axis_tready = !q_full && !busy_q;
	assign q_push        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		q_cmd.slot  = slot;
		q_cmd.owner = owner;
		q_cmd.kind  = CMD_NOP;
		if (!info.present) begin
			q_cmd.kind = CMD_NO_TABLE;
		end else begin
			unique case (op)
				OP_ALLOC:   q_cmd.kind = id_ok ? CMD_ALLOC : CMD_BAD_ID;
				OP_RELEASE: q_cmd.kind = slot_ok ? CMD_RELEASE : CMD_BAD_SLOT;
				OP_READ:    q_cmd.kind = slot_ok ? CMD_READ : CMD_BAD_SLOT;
				default:    q_cmd.kind = CMD_NOP;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/ffsa_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// ffsa_cmd_fifo
// Two-entry queue of classified commands between front and engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_cmd_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire  ffsa_pkg::cmd_t  push_cmd,
	output logic                  full,
	input  wire                   pop,
	output logic                  head_valid,
	output ffsa_pkg::cmd_t        head
);
	import ffsa_pkg::*;

	cmd_t        entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- src/ffsa_engine.sv -----
// ----------------------------------------------------------------------------
// ffsa_engine
// Owns the slot table: owner memory, used bitmap, counts and configuration.
// Runs one command at a time and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_engine #(
	parameter int MAX_SLOTS  = ffsa_pkg::MAX_SLOTS_DEF,
	parameter int OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [ffsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [ffsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	output ffsa_pkg::tbl_info_t                 info,
	input  wire                                 head_valid,
	input  wire  ffsa_pkg::cmd_t                head,
	output logic                                pop,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// status [2:0], granted_slot [10:3], prior_owner [26:11],
	// free_count [35:27], used_count [44:36], zero [47:45]
	output logic [ffsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import ffsa_pkg::*;

	localparam int NumGroups = (MAX_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int Depth     = NumGroups * GROUP_SIZE;
	localparam int IdxW      = $clog2(Depth);
	localparam int CntW      = $clog2(MAX_SLOTS + 1);

	// Table storage and control state
	logic [OWNER_BITS-1:0]  mem [Depth];
	logic [OWNER_BITS-1:0]  rd_q;
	logic [Depth-1:0]       used_q;
	logic [Depth-1:0]       mask_q;
	logic [CFG_DATA_W-1:0]  cap_q;
	logic                   present_q;
	logic [CntW-1:0]        active_cap_q;
	logic [CntW-1:0]        free_q;
	eng_state_t             state_q, state_d;
	cmd_t                   cmd_q;

	// Group search registers
	logic [NumGroups-1:0]   grp_any_q;
	logic [GROUP_BITS-1:0]  grp_off_q [NumGroups];
	logic [NumGroups-1:0]   grp_any_d;
	logic [GROUP_BITS-1:0]  grp_off_d [NumGroups];
	logic [Depth-1:0]       avail;

	// Output register
	logic                   out_valid_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	// Per-command combinational results
	logic [IdxW-1:0]        rd_addr;
	logic [IdxW-1:0]        cmd_idx;
	logic [31:0]            head_slot32;
	logic [31:0]            cmd_slot32;
	logic [31:0]            alloc_idx32;
	logic [IdxW-1:0]        alloc_idx;
	logic                   alloc_found;
	logic                   load_out;
	logic                   set_used;
	logic                   clr_used;
	status_t                res_status;
	logic [31:0]            res_granted;
	logic [31:0]            res_prior;
	logic [CntW-1:0]        free_nxt;
	logic [31:0]            res_free;
	logic [31:0]            res_used;
	logic [31:0]            owner32;
	logic                   cfg_we;
	logic                   create;
	logic [31:0]            cap_clamped;
	logic [Depth-1:0]       mask_new;

	assign cfg_ready       = 1'b1;
	assign cfg_we          = cfg_valid && cfg_ready;
	assign create          = cfg_we && (cfg_reg_t'(cfg_index) == REG_TABLE_PRESENT) && cfg_data[0];
	assign info.present    = present_q;
	assign info.active_cap = CAP_BITS'(active_cap_q);

	// Capacity latched at creation, held inside 1..MAX_SLOTS
	always_comb begin
		cap_clamped = {{(32-CFG_DATA_W){1'b0}}, cap_q};
		if (cap_clamped == 32'd0) begin
			cap_clamped = 32'd1;
		end else if (cap_clamped > 32'(MAX_SLOTS)) begin
			cap_clamped = 32'(MAX_SLOTS);
		end
		for (int i = 0; i < Depth; i++) begin
			mask_new[i] = 32'(i) < cap_clamped;
		end
	end

	// First free slot inside each group
	assign avail = mask_q & ~used_q;

	always_comb begin
		for (int g = 0; g < NumGroups; g++) begin
			grp_any_d[g] = |avail[g*GROUP_SIZE +: GROUP_SIZE];
			grp_off_d[g] = '0;
			for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
				if (avail[g*GROUP_SIZE + b]) begin
					grp_off_d[g] = GROUP_BITS'(b);
				end
			end
		end
	end

	// Lowest group with room gives the slot
	always_comb begin
		alloc_found = 1'b0;
		alloc_idx32 = '0;
		for (int g = NumGroups - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				alloc_found = 1'b1;
				alloc_idx32 = 32'(g) * GROUP_SIZE + 32'(grp_off_q[g]);
			end
		end
	end

	assign alloc_idx   = alloc_idx32[IdxW-1:0];
	assign head_slot32 = {{(32-SLOT_W){1'b0}}, head.slot};
	assign cmd_slot32  = {{(32-SLOT_W){1'b0}}, cmd_q.slot};
	assign rd_addr     = head_slot32[IdxW-1:0];
	assign cmd_idx     = cmd_slot32[IdxW-1:0];
	assign owner32     = {{(32-OWNER_W){1'b0}}, cmd_q.owner};

	// Sequencer: pop and read in IDLE, resolve and commit in EXEC once the output is free
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ENG_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					state_d = ENG_EXEC;
				end
			end
			ENG_EXEC: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = ENG_IDLE;
				end
			end
			default: state_d = ENG_IDLE;
		endcase
	end

	always_comb begin
		res_status  = ST_OK;
		res_granted = '0;
		res_prior   = '0;
		free_nxt    = free_q;
		set_used    = 1'b0;
		clr_used    = 1'b0;
		case (cmd_q.kind)
			CMD_NO_TABLE: res_status = ST_NO_TABLE;
			CMD_BAD_ID:   res_status = ST_BAD_ID;
			CMD_BAD_SLOT: res_status = ST_BAD_SLOT;
			CMD_ALLOC: begin
				if (alloc_found) begin
					set_used    = 1'b1;
					res_granted = alloc_idx32;
					if (free_q != '0) begin
						free_nxt = free_q - CntW'(1);
					end
				end else begin
					res_status = ST_FULL;
				end
			end
			CMD_RELEASE: begin
				if (!used_q[cmd_idx]) begin
					res_status = ST_ALREADY_FREE;
				end else begin
					clr_used  = 1'b1;
					res_prior = 32'(rd_q);
					if (free_q < active_cap_q) begin
						free_nxt = free_q + CntW'(1);
					end
				end
			end
			CMD_READ: begin
				if (used_q[cmd_idx]) begin
					res_prior = 32'(rd_q);
				end
			end
			default: res_status = ST_OK;
		endcase
		if (cmd_q.kind == CMD_NO_TABLE) begin
			res_free = '0;
			res_used = '0;
		end else begin
			res_free = 32'(free_nxt);
			res_used = 32'(active_cap_q - free_nxt);
		end
	end

	// Owner memory: write on a granted allocate, read when a command is popped
	always_ff @(posedge clk) begin
		if (load_out && set_used) begin
			mem[alloc_idx] <= owner32[OWNER_BITS-1:0];
		end
		if (pop) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Command and search registers, taken on pop
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q     <= head;
			grp_any_q <= grp_any_d;
			for (int g = 0; g < NumGroups; g++) begin
				grp_off_q[g] <= grp_off_d[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= {{(OUT_TDATA_W-STATUS_W-SLOT_W-OWNER_W-2*COUNT_W){1'b0}},
				res_used[COUNT_W-1:0], res_free[COUNT_W-1:0],
				res_prior[OWNER_W-1:0], res_granted[SLOT_W-1:0], res_status};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ENG_IDLE;
			out_valid_q  <= 1'b0;
			used_q       <= '0;
			mask_q       <= '0;
			cap_q        <= CAPACITY_RESET;
			present_q    <= 1'b0;
			active_cap_q <= '0;
			free_q       <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_CAPACITY:      cap_q <= cfg_data;
					REG_TABLE_PRESENT: present_q <= cfg_data[0];
					default:           cap_q <= cap_q;
				endcase
			end
			// Creation drops every slot and reloads the counts
			if (create) begin
				used_q       <= '0;
				mask_q       <= mask_new;
				active_cap_q <= cap_clamped[CntW-1:0];
				free_q       <= cap_clamped[CntW-1:0];
			end else if (load_out) begin
				free_q <= free_nxt;
				if (set_used) begin
					used_q[alloc_idx] <= 1'b1;
				end
				if (clr_used) begin
					used_q[cmd_idx] <= 1'b0;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- src/first_fit_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// first_fit_slot_allocator_unit
// Slot table with first-fit allocate, release and read of owner ids.
//
//   channel   direction  transfer on              payload
//   s_axis    in         s_axis_tvalid & tready   op, slot_index, owner_id
//   m_axis    out        m_axis_tvalid & tready   status, granted_slot,
//                                                 prior_owner, free/used count
//   cfg       in         cfg_valid & cfg_ready    cfg_index, cfg_data
//
// In the engine a request first pops the command queue, reads the owner memory
// and registers the per-group free-slot search, then resolves the lowest free
// slot and commits. The front accepts into a two-entry queue while the engine
// works or the result waits. Reset empties the table (no clearing pass); s_axis
// is held off by a registered flag right after reset. A result not taken holds
// the engine in its commit state; the queue keeps taking transfers until it is
// full, then s_axis stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_slot_allocator_unit #(
	parameter int MAX_SLOTS  = ffsa_pkg::MAX_SLOTS_DEF,
	parameter int OWNER_BITS = ffsa_pkg::OWNER_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// op [1:0], slot_index [9:2], owner_id [25:10], zero [31:26]
	input  wire  [ffsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// status [2:0], granted_slot [10:3], prior_owner [26:11],
	// free_count [35:27], used_count [44:36], zero [47:45]
	output logic [ffsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [ffsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [ffsa_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ffsa_pkg::*;

	tbl_info_t  info;
	logic       q_full;
	logic       q_push;
	cmd_t       q_cmd;
	logic       q_pop;
	logic       q_valid;
	cmd_t       q_head;

	ffsa_front #(
		.OWNER_BITS (OWNER_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.info          (info),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	ffsa_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	ffsa_engine #(
		.MAX_SLOTS  (MAX_SLOTS),
		.OWNER_BITS (OWNER_BITS)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.info          (info),
		.head_valid    (q_valid),
		.head          (q_head),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

endmodule

`default_nettype wire
